// ===== hw/rtl/sprite_animation_sequencer_defines.svh =====
// Assertion macros for the sprite animation sequencer.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define SAS_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("check failed");
`define SAS_ASSERT_NEXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) else $error("check failed");
`else
`define SAS_ASSERT(lbl, ck, rn, prop)
`define SAS_ASSERT_NEXT(lbl, ck, rn, a, b)
`endif

`endif

// ===== hw/rtl/sas_pkg.sv =====
package sas_pkg;

    localparam int QUEUE_DEPTH        = 8;
    localparam int UPDATES_PER_SECOND = 60;
    localparam int IDX_W              = $clog2(QUEUE_DEPTH);
    localparam int CNT_W              = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_LOOPS  = 3'd1,
        OP_FRAMES = 3'd2,
        OP_SOFT   = 3'd3,
        OP_HARD   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDIV,
        ST_LMUL,
        ST_APPLY,
        ST_TPF_GO,
        ST_TPF,
        ST_TDIV,
        ST_MDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [10:0] anim_start;
        logic [7:0]  anim_count;
        logic [7:0]  anim_fps;
        logic [15:0] amount;
        logic        play_backwards;
        logic        flip_x;
        logic        flip_y;
    } req_t;

    typedef struct packed {
        logic [11:0] sprite_index;
        logic        mirror_h;
        logic        mirror_v;
        logic        active;
        logic        dropped;
        logic [3:0]  entries;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [7:0]  remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/sas_div.sv =====
`include "sprite_animation_sequencer_defines.svh"

module sas_div (
    input  logic             clk,
    input  logic             rst_n,
    input  sas_pkg::div_cmd_t cmd,
    output sas_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [8:0]  shifted;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = cmd.dividend;
            rem_next  = '0;
            dvs_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 8'(shifted - {1'b0, dvs_reg}) : shifted[7:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `SAS_ASSERT(a_no_restart, clk, rst_n, cmd.start |-> !busy_reg)
    `SAS_ASSERT_NEXT(a_start_busy, clk, rst_n, cmd.start, busy_reg)
    `SAS_ASSERT(a_done_idle, clk, rst_n, done_reg |-> !busy_reg)

endmodule

// ===== hw/rtl/sprite_animation_sequencer.sv =====
// Sprite animation sequencer: a queue of up to eight animation entries, of which the
// front one plays. One request beat is taken at a time and the request side stalls until
// its response beat is taken. All division goes through one shared 32-step bit-serial
// divider: loop duration (enqueue by loops and switches), ticks per frame, timer over
// ticks per frame and the frame modulo. When the queue is empty after the request is
// applied, the ticks per frame, timer and modulo divides are skipped; the frame modulo
// is also skipped when the front entry has a zero frame count. The next request beat
// can be taken in the cycle after the response beat.
`include "sprite_animation_sequencer_defines.svh"

module sprite_animation_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sas_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sas_pkg::rsp_t rsp
);

    localparam int DEPTH = sas_pkg::QUEUE_DEPTH;
    localparam int IW    = sas_pkg::IDX_W;
    localparam int CW    = sas_pkg::CNT_W;

    sas_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            dropped_reg, dropped_next;
    sas_pkg::req_t   item_reg, item_next;
    logic [31:0]     dur_reg, dur_next;
    logic [15:0]     quo_reg, quo_next;
    logic [7:0]      off_reg, off_next;
    logic [7:0]      tpf_reg, tpf_next;

    logic [31:0] timer_mem [DEPTH];
    logic [31:0] dur_mem   [DEPTH];
    logic [10:0] start_mem [DEPTH];
    logic [7:0]  count_mem [DEPTH];
    logic [7:0]  fps_mem   [DEPTH];
    logic [2:0]  flags_mem [DEPTH];

    sas_pkg::div_cmd_t div_cmd;
    sas_pkg::div_rsp_t div_rsp;

    logic [CW-1:0] fill_trim;
    logic [CW:0]   tail_sum;
    logic [IW-1:0] tail_idx;
    logic          is_push, full, push_we, tick_we, expired;
    logic [31:0]   push_dur, new_timer, head_timer;
    logic [7:0]    head_fps;
    logic [7:0]    req_fps;

    sas_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .cmd (div_cmd),
        .rsp (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sas_pkg::ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            tpf_reg   <= 8'd1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            tpf_reg   <= tpf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dropped_reg <= dropped_next;
        item_reg    <= item_next;
        dur_reg     <= dur_next;
        quo_reg     <= quo_next;
        off_reg     <= off_next;
        if (push_we)
        begin
            timer_mem[tail_idx] <= item_reg.play_backwards ? push_dur : 32'd0;
            dur_mem[tail_idx]   <= push_dur;
            start_mem[tail_idx] <= item_reg.anim_start;
            count_mem[tail_idx] <= item_reg.anim_count;
            fps_mem[tail_idx]   <= item_reg.anim_fps;
            flags_mem[tail_idx] <= {item_reg.flip_y, item_reg.flip_x, item_reg.play_backwards};
        end
        if (tick_we)
        begin
            timer_mem[head_reg] <= new_timer;
        end
    end

    always_comb
    begin
        req_fps    = (req.anim_fps == 8'd0) ? 8'd1 : req.anim_fps;
        head_fps   = (fps_mem[head_reg] == 8'd0) ? 8'd1 : fps_mem[head_reg];
        head_timer = timer_mem[head_reg];

        unique case (item_reg.operation)
            sas_pkg::OP_SOFT: fill_trim = (fill_reg > CW'(1)) ? CW'(1) : fill_reg;
            sas_pkg::OP_HARD: fill_trim = '0;
            default:          fill_trim = fill_reg;
        endcase
        is_push = (item_reg.operation == sas_pkg::OP_LOOPS)
               || (item_reg.operation == sas_pkg::OP_FRAMES)
               || (item_reg.operation == sas_pkg::OP_SOFT)
               || (item_reg.operation == sas_pkg::OP_HARD);
        full     = fill_trim >= CW'(DEPTH);
        tail_sum = (CW+1)'(head_reg) + (CW+1)'(fill_trim);
        tail_idx = (tail_sum >= (CW+1)'(DEPTH)) ? IW'(tail_sum - (CW+1)'(DEPTH))
                                                : IW'(tail_sum);
        push_dur = (item_reg.operation == sas_pkg::OP_FRAMES) ? 32'(item_reg.amount) : dur_reg;

        if (flags_mem[head_reg][0])
        begin
            new_timer = head_timer - 32'd1;
            expired   = (new_timer == 32'd0) || (new_timer > dur_mem[head_reg]);
        end
        else
        begin
            new_timer = head_timer + 32'd1;
            expired   = new_timer >= dur_mem[head_reg];
        end

        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        item_next    = item_reg;
        dur_next     = dur_reg;
        quo_next     = quo_reg;
        off_next     = off_reg;
        tpf_next     = tpf_reg;
        push_we      = 1'b0;
        tick_we      = 1'b0;
        div_cmd      = '0;

        unique case (state_reg)
            sas_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    if ((req.operation == sas_pkg::OP_LOOPS)
                        || (req.operation == sas_pkg::OP_SOFT)
                        || (req.operation == sas_pkg::OP_HARD))
                    begin
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = 32'(req.anim_count)
                                         * 32'(sas_pkg::UPDATES_PER_SECOND);
                        div_cmd.divisor  = req_fps;
                        state_next       = sas_pkg::ST_LDIV;
                    end
                    else
                    begin
                        state_next = sas_pkg::ST_APPLY;
                    end
                end
            end
            sas_pkg::ST_LDIV:
            begin
                if (div_rsp.done)
                begin
                    quo_next   = div_rsp.quotient[15:0];
                    state_next = sas_pkg::ST_LMUL;
                end
            end
            sas_pkg::ST_LMUL:
            begin
                dur_next   = 32'(item_reg.amount) * 32'(quo_reg);
                state_next = sas_pkg::ST_APPLY;
            end
            sas_pkg::ST_APPLY:
            begin
                dropped_next = 1'b0;
                off_next     = '0;
                if (is_push)
                begin
                    fill_next = fill_trim;
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        push_we   = 1'b1;
                        fill_next = fill_trim + CW'(1);
                    end
                end
                else if ((item_reg.operation == sas_pkg::OP_TICK) && (fill_reg != '0))
                begin
                    tick_we = 1'b1;
                    if (expired && (fill_reg > CW'(1)))
                    begin
                        head_next = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
                        fill_next = fill_reg - CW'(1);
                    end
                end
                state_next = sas_pkg::ST_TPF_GO;
            end
            sas_pkg::ST_TPF_GO:
            begin
                if (fill_reg == '0)
                begin
                    state_next = sas_pkg::ST_DONE;
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = 32'(sas_pkg::UPDATES_PER_SECOND);
                    div_cmd.divisor  = head_fps;
                    state_next       = sas_pkg::ST_TPF;
                end
            end
            sas_pkg::ST_TPF:
            begin
                if (div_rsp.done)
                begin
                    tpf_next   = (div_rsp.quotient[7:0] == 8'd0) ? 8'd1
                                                                 : div_rsp.quotient[7:0];
                    state_next = sas_pkg::ST_TDIV;
                end
            end
            sas_pkg::ST_TDIV:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = head_timer;
                div_cmd.divisor  = tpf_reg;
                state_next       = sas_pkg::ST_MDIV;
            end
            sas_pkg::ST_MDIV:
            begin
                if (div_rsp.done)
                begin
                    if (count_mem[head_reg] == 8'd0)
                    begin
                        state_next = sas_pkg::ST_DONE;
                    end
                    else
                    begin
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = div_rsp.quotient;
                        div_cmd.divisor  = count_mem[head_reg];
                        state_next       = sas_pkg::ST_DONE;
                        tpf_next         = 8'd0;
                    end
                end
            end
            sas_pkg::ST_DONE:
            begin
                if (tpf_reg == 8'd0)
                begin
                    if (div_rsp.done)
                    begin
                        off_next = div_rsp.remainder;
                        tpf_next = 8'd1;
                    end
                end
                else if (!rsp_stall)
                begin
                    state_next = sas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sas_pkg::ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != sas_pkg::ST_IDLE);
    assign rsp_valid = (state_reg == sas_pkg::ST_DONE) && (tpf_reg != 8'd0);

    always_comb
    begin
        rsp = '0;
        rsp.active  = (fill_reg != '0);
        rsp.dropped = dropped_reg;
        rsp.entries = 4'(fill_reg);
        if (fill_reg != '0)
        begin
            rsp.sprite_index = 12'(start_mem[head_reg]) + 12'(off_reg);
            rsp.mirror_h     = flags_mem[head_reg][1];
            rsp.mirror_v     = flags_mem[head_reg][2];
        end
    end

    `SAS_ASSERT(a_fill_range, clk, rst_n, fill_reg <= CW'(DEPTH))
    `SAS_ASSERT(a_head_range, clk, rst_n, head_reg <= IW'(DEPTH - 1))
    `SAS_ASSERT(a_rsp_blocks_req, clk, rst_n, rsp_valid |-> req_stall)
    `SAS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)

endmodule

// ===== test/tb_sprite_animation_sequencer.sv =====
module tb_sprite_animation_sequencer;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BEATS   = 650;
    localparam int LONG_HOLD      = 600;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    sas_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    sas_pkg::rsp_t  rsp;

    sprite_animation_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // animation queue shadow
    logic [31:0] q_timer    [sas_pkg::QUEUE_DEPTH];
    logic [31:0] q_duration [sas_pkg::QUEUE_DEPTH];
    logic [10:0] q_start    [sas_pkg::QUEUE_DEPTH];
    logic [7:0]  q_count    [sas_pkg::QUEUE_DEPTH];
    logic [7:0]  q_fps      [sas_pkg::QUEUE_DEPTH];
    logic        q_back     [sas_pkg::QUEUE_DEPTH];
    logic        q_mx       [sas_pkg::QUEUE_DEPTH];
    logic        q_my       [sas_pkg::QUEUE_DEPTH];
    int unsigned q_head;
    int unsigned q_fill;

    sas_pkg::rsp_t frame_queue[$];
    int            mismatches;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            long_hold;
    int            quiet_cycles;

    typedef struct {
        sas_pkg::req_t beat;
        bit            has_exp;
        sas_pkg::rsp_t exp;
    } vec_t;
    vec_t directed[$];

    function automatic bit push_anim(sas_pkg::req_t r, logic [31:0] dur);
        int unsigned s;
        if (q_fill >= sas_pkg::QUEUE_DEPTH)
            return 1'b0;
        s = (q_head + q_fill) % sas_pkg::QUEUE_DEPTH;
        q_start[s]    = r.anim_start;
        q_count[s]    = r.anim_count;
        q_fps[s]      = r.anim_fps;
        q_duration[s] = dur;
        q_timer[s]    = r.play_backwards ? dur : 32'd0;
        q_back[s]     = r.play_backwards;
        q_mx[s]       = r.flip_x;
        q_my[s]       = r.flip_y;
        q_fill++;
        return 1'b1;
    endfunction

    function automatic sas_pkg::rsp_t predict_frame(sas_pkg::req_t r);
        sas_pkg::rsp_t o;
        logic [31:0]   fps_eff;
        logic [31:0]   loop_dur;
        logic [31:0]   tpf;
        logic [31:0]   ofs;
        int unsigned   s;
        bit            expired;
        bit            dropped;
        fps_eff  = (r.anim_fps == 8'd0) ? 32'd1 : {24'd0, r.anim_fps};
        loop_dur = {16'd0, r.amount}
                 * ((32'(r.anim_count) * 32'(sas_pkg::UPDATES_PER_SECOND)) / fps_eff);
        dropped  = 1'b0;
        case (r.operation)
            sas_pkg::OP_TICK:
                if (q_fill != 0)
                begin
                    s = q_head;
                    if (q_back[s])
                    begin
                        q_timer[s] = q_timer[s] - 32'd1;
                        expired = (q_timer[s] == 32'd0) || (q_timer[s] > q_duration[s]);
                    end
                    else
                    begin
                        q_timer[s] = q_timer[s] + 32'd1;
                        expired = q_timer[s] >= q_duration[s];
                    end
                    if (expired && q_fill > 1)
                    begin
                        q_head = (q_head + 1) % sas_pkg::QUEUE_DEPTH;
                        q_fill--;
                    end
                end
            sas_pkg::OP_LOOPS:  dropped = !push_anim(r, loop_dur);
            sas_pkg::OP_FRAMES: dropped = !push_anim(r, {16'd0, r.amount});
            sas_pkg::OP_SOFT:
            begin
                if (q_fill > 1)
                    q_fill = 1;
                dropped = !push_anim(r, loop_dur);
            end
            sas_pkg::OP_HARD:
            begin
                q_fill = 0;
                dropped = !push_anim(r, loop_dur);
            end
            default: ;
        endcase
        o = '0;
        if (q_fill > 0)
        begin
            s   = q_head;
            tpf = 32'(sas_pkg::UPDATES_PER_SECOND)
                / ((q_fps[s] == 8'd0) ? 32'd1 : 32'(q_fps[s]));
            if (tpf == 32'd0)
                tpf = 32'd1;
            ofs = (q_count[s] == 8'd0) ? 32'd0 : (q_timer[s] / tpf) % 32'(q_count[s]);
            o.sprite_index = 12'(32'(q_start[s]) + ofs);
            o.mirror_h     = q_mx[s];
            o.mirror_v     = q_my[s];
        end
        o.active  = q_fill > 0;
        o.dropped = dropped;
        o.entries = 4'(q_fill);
        return o;
    endfunction

    function automatic sas_pkg::req_t make_beat(logic [2:0] op, logic [10:0] st,
                                                logic [7:0] cnt, logic [7:0] fps,
                                                logic [15:0] amt, logic [2:0] fl);
        sas_pkg::req_t r;
        r.operation      = op;
        r.anim_start     = st;
        r.anim_count     = cnt;
        r.anim_fps       = fps;
        r.amount         = amt;
        r.play_backwards = fl[2];
        r.flip_x         = fl[1];
        r.flip_y         = fl[0];
        return r;
    endfunction

    function automatic sas_pkg::req_t random_beat();
        sas_pkg::req_t r;
        logic [63:0]   raw;
        int            pick;
        raw  = {$urandom, $urandom};
        r    = raw[$bits(sas_pkg::req_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.operation = sas_pkg::OP_TICK;
        else if (pick < 68)
            r.operation = sas_pkg::OP_LOOPS;
        else if (pick < 86)
            r.operation = sas_pkg::OP_FRAMES;
        else if (pick < 92)
            r.operation = sas_pkg::OP_SOFT;
        else if (pick < 96)
            r.operation = sas_pkg::OP_HARD;
        else
            r.operation = 3'($urandom_range(5, 7));
        // short timers so entries actually expire and pop
        if ($urandom_range(0, 9) < 8)
        begin
            r.amount    = 16'($urandom_range(0, 6));
            r.anim_fps  = 8'($urandom_range(20, 255));
            r.anim_count = 8'($urandom_range(0, 4));
        end
        return r;
    endfunction

    task automatic add_vec(sas_pkg::req_t r, bit has_exp, sas_pkg::rsp_t e);
        vec_t v;
        v.beat    = r;
        v.has_exp = has_exp;
        v.exp     = e;
        directed.push_back(v);
    endtask

    task automatic send_beat(sas_pkg::req_t r);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // receiver side
    initial
    begin
        bit hold_seen;
        hold_seen = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_seen)
            begin
                hold_seen = 1'b1;
                repeat (LONG_HOLD)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (frame_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %p", rsp);
            end
            else
            begin
                sas_pkg::rsp_t e;
                e = frame_queue.pop_front();
                if (rsp !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %p got %p", e, rsp);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        sas_pkg::rsp_t e;
        sas_pkg::req_t r;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        long_hold      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        q_head         = 0;
        q_fill         = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        e = '0;
        add_vec(make_beat(sas_pkg::OP_TICK, 11'd5, 8'd1, 8'd1, 16'd1, 3'b111), 1'b1, e);
        add_vec(make_beat(3'd7, 11'h7ff, 8'hff, 8'hff, 16'hffff, 3'b111), 1'b1, e);
        e = '0; e.active = 1'b1; e.entries = 4'd1; e.sprite_index = 12'h7ff;
        e.mirror_h = 1'b1; e.mirror_v = 1'b1;
        add_vec(make_beat(sas_pkg::OP_LOOPS, 11'h7ff, 8'hff, 8'hff, 16'hffff, 3'b011), 1'b1, e);
        add_vec(make_beat(sas_pkg::OP_TICK, 11'd0, 8'd0, 8'd0, 16'd0, 3'b000), 1'b0, e);
        add_vec(make_beat(sas_pkg::OP_FRAMES, 11'd0, 8'd0, 8'd0, 16'd0, 3'b100), 1'b0, e);
        add_vec(make_beat(sas_pkg::OP_FRAMES, 11'd3, 8'd4, 8'd60, 16'd2, 3'b100), 1'b0, e);
        for (int i = 0; i < 6; i++)
            add_vec(make_beat(sas_pkg::OP_FRAMES, 11'(i * 100), 8'd3, 8'd30, 16'd3, 3'(i)),
                    1'b0, e);
        add_vec(make_beat(sas_pkg::OP_LOOPS, 11'd9, 8'd2, 8'd2, 16'd1, 3'b000), 1'b0, e);
        add_vec(make_beat(sas_pkg::OP_SOFT, 11'd1, 8'd5, 8'd7, 16'd2, 3'b110), 1'b0, e);
        for (int i = 0; i < 4; i++)
            add_vec(make_beat(sas_pkg::OP_TICK, 11'd0, 8'd0, 8'd0, 16'd0, 3'b000), 1'b0, e);
        add_vec(make_beat(sas_pkg::OP_HARD, 11'd100, 8'd6, 8'd255, 16'd1, 3'b101), 1'b0, e);
        add_vec(make_beat(sas_pkg::OP_SOFT, 11'd50, 8'd1, 8'd1, 16'd0, 3'b000), 1'b0, e);
        add_vec(make_beat(sas_pkg::OP_TICK, 11'd0, 8'd0, 8'd0, 16'd0, 3'b000), 1'b0, e);
        add_vec(make_beat(3'd5, 11'd0, 8'd0, 8'd0, 16'd0, 3'b000), 1'b0, e);
        add_vec(make_beat(3'd6, 11'd0, 8'd0, 8'd0, 16'd0, 3'b000), 1'b0, e);

        foreach (directed[i])
        begin
            e = predict_frame(directed[i].beat);
            frame_queue.push_back(directed[i].has_exp ? directed[i].exp : e);
            send_beat(directed[i].beat);
        end
        // fill the queue, then overflow
        for (int i = 0; i < 9; i++)
        begin
            r = make_beat(sas_pkg::OP_FRAMES, 11'(i), 8'd2, 8'd10, 16'd5, 3'b000);
            e = predict_frame(r);
            if (i == 8)
            begin
                e.dropped = 1'b1;
                e.entries = 4'd8;
            end
            frame_queue.push_back(e);
            send_beat(r);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (ph == 2)
                long_hold = 1'b1;
            for (int k = 0; k < RANDOM_BEATS / 4; k++)
            begin
                r = random_beat();
                frame_queue.push_back(predict_frame(r));
                send_beat(r);
            end
        end
        req_valid <= 1'b0;
        while (frame_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
